>>> rtl/i2cms_pkg.sv
`timescale 1ns / 1ps

package i2cms_pkg;

    // Buffer geometry
    localparam int BUF_DEPTH = 16;
    localparam int IDX_W     = $clog2(BUF_DEPTH + 1);
    localparam int ADDR_W    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int CMP_W     = IDX_W + 2;

    // Item kinds
    localparam logic [2:0] K_SETUP  = 3'd0;
    localparam logic [2:0] K_PUSH   = 3'd1;
    localparam logic [2:0] K_LAUNCH = 3'd2;
    localparam logic [2:0] K_EVENT  = 3'd3;
    localparam logic [2:0] K_POP    = 3'd4;
    localparam logic [2:0] K_KILL   = 3'd5;

    // Phases
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_START   = 2'd1;
    localparam logic [1:0] PH_ADDRESS = 2'd2;
    localparam logic [1:0] PH_DATA    = 2'd3;

    // Transfer types
    localparam logic [1:0] TY_WRITE  = 2'd0;
    localparam logic [1:0] TY_READ   = 2'd1;
    localparam logic [1:0] TY_ATOMIC = 2'd2;

    // Bus commands
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_NACK  = 3'd2;
    localparam logic [2:0] CMD_ACK   = 3'd3;
    localparam logic [2:0] CMD_STOP  = 3'd4;

    // Bus status codes
    localparam logic [7:0] ST_MASK         = 8'hF8;
    localparam logic [7:0] ST_START        = 8'h08;
    localparam logic [7:0] ST_RSTART       = 8'h10;
    localparam logic [7:0] ST_MT_SLA_ACK   = 8'h18;
    localparam logic [7:0] ST_MT_SLA_NACK  = 8'h20;
    localparam logic [7:0] ST_MT_DATA_ACK  = 8'h28;
    localparam logic [7:0] ST_MT_DATA_NACK = 8'h30;
    localparam logic [7:0] ST_MR_SLA_ACK   = 8'h40;
    localparam logic [7:0] ST_MR_SLA_NACK  = 8'h48;
    localparam logic [7:0] ST_MR_DATA_ACK  = 8'h50;
    localparam logic [7:0] ST_MR_DATA_NACK = 8'h58;

    // Status reporting
    localparam logic [7:0] STAT_BUSY   = 8'hFF;
    localparam logic [7:0] STAT_WCUT   = 8'h80;
    localparam logic [7:0] STAT_RCUT   = 8'h40;
    localparam logic [7:0] POP_EMPTY   = 8'hFF;
    localparam logic [7:0] ADDR_MASK   = 8'hFE;

    typedef struct packed {
        logic [2:0] kind;
        logic [4:0] read_count;
        logic [7:0] write_data;
        logic [7:0] device_address;
        logic [7:0] bus_status;
        logic [7:0] rx_byte;
    } t_in;

    typedef struct packed {
        logic       accepted;
        logic [2:0] bus_command;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [7:0] read_data;
        logic [7:0] error_status;
        logic [7:0] completion_status;
    } t_out;

endpackage

>>> rtl/i2cms_core.sv
`timescale 1ns / 1ps

// Sequencer state, byte stores and the per-item step logic.
module i2cms_core
    import i2cms_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_step,
    input  t_in  i_item,
    output t_out o_result
);

    localparam logic [IDX_W-1:0] DEPTH_I = IDX_W'(BUF_DEPTH);

    logic [1:0]       r_phase, n_phase;
    logic [1:0]       r_type, n_type;
    logic [IDX_W-1:0] r_fill, n_fill;
    logic [IDX_W-1:0] r_send, n_send;
    logic [IDX_W-1:0] r_rcv, n_rcv;
    logic [IDX_W-1:0] r_drain, n_drain;
    logic [IDX_W-1:0] r_exp, n_exp;
    logic [7:0]       r_err, n_err;
    logic [7:0]       r_target, n_target;

    logic [7:0] r_tx_mem [BUF_DEPTH];
    logic [7:0] r_rx_mem [BUF_DEPTH];

    logic       tx_we, rx_we;
    logic [7:0] st;
    logic [7:0] tx_rd, rx_rd;
    t_out       res;

    assign st    = i_item.bus_status & ST_MASK;
    assign tx_rd = r_tx_mem[r_send[ADDR_W-1:0]];
    assign rx_rd = r_rx_mem[r_drain[ADDR_W-1:0]];

    always_comb begin
        n_phase  = r_phase;
        n_type   = r_type;
        n_fill   = r_fill;
        n_send   = r_send;
        n_rcv    = r_rcv;
        n_drain  = r_drain;
        n_exp    = r_exp;
        n_err    = r_err;
        n_target = r_target;
        tx_we    = 1'b0;
        rx_we    = 1'b0;
        res      = '0;

        case (i_item.kind)
            K_SETUP: begin
                if (CMP_W'(i_item.read_count) > CMP_W'(BUF_DEPTH)) begin
                    n_exp = DEPTH_I;
                end else begin
                    n_exp = IDX_W'(i_item.read_count);
                end
                n_fill  = '0;
                n_send  = '0;
                n_rcv   = '0;
                n_drain = '0;
            end
            K_PUSH: begin
                if (r_fill < DEPTH_I) begin
                    tx_we        = 1'b1;
                    n_fill       = r_fill + 1'b1;
                    res.accepted = 1'b1;
                end
            end
            K_LAUNCH: begin
                if (r_phase == PH_IDLE) begin
                    n_err    = '0;
                    n_target = i_item.device_address & ADDR_MASK;
                    if (r_fill != '0 || r_exp != '0) begin
                        if (r_fill != '0) begin
                            n_type = (r_exp != '0) ? TY_ATOMIC : TY_WRITE;
                        end else begin
                            n_type = TY_READ;
                        end
                        res.bus_command = CMD_START;
                        n_phase         = PH_START;
                        res.accepted    = 1'b1;
                    end
                end
            end
            K_EVENT: begin
                case (r_phase)
                    PH_START: begin
                        if (st == ST_START || st == ST_RSTART) begin
                            res.tx_valid    = 1'b1;
                            res.tx_byte     = r_target | {7'd0, r_type == TY_READ};
                            res.bus_command = CMD_NACK;
                            n_phase         = PH_ADDRESS;
                        end else begin
                            n_err   = st;
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_ADDRESS: begin
                        if (r_type == TY_READ) begin
                            if (st == ST_MR_SLA_ACK) begin
                                res.bus_command = (r_exp == IDX_W'(1)) ? CMD_NACK : CMD_ACK;
                                n_phase         = PH_DATA;
                            end else if (st == ST_MR_SLA_NACK) begin
                                res.bus_command = CMD_STOP;
                                n_phase         = PH_IDLE;
                            end else begin
                                n_err   = st;
                                n_phase = PH_IDLE;
                            end
                        end else begin
                            if (st == ST_MT_SLA_ACK) begin
                                res.tx_valid    = 1'b1;
                                if (r_send < DEPTH_I) begin
                                    res.tx_byte = tx_rd;
                                    n_send      = r_send + 1'b1;
                                end
                                res.bus_command = CMD_NACK;
                                n_phase         = PH_DATA;
                            end else if (st == ST_MT_SLA_NACK) begin
                                res.bus_command = CMD_STOP;
                                n_phase         = PH_IDLE;
                            end else begin
                                n_err   = st;
                                n_phase = PH_IDLE;
                            end
                        end
                    end
                    PH_DATA: begin
                        if (r_type == TY_READ) begin
                            if (r_rcv < DEPTH_I) begin
                                rx_we = 1'b1;
                                n_rcv = r_rcv + 1'b1;
                            end
                            if (st == ST_MR_DATA_ACK) begin
                                if (n_rcv == r_exp || n_rcv >= DEPTH_I) begin
                                    res.bus_command = CMD_STOP;
                                    n_phase         = PH_IDLE;
                                end else if (CMP_W'(n_rcv) + 1'b1 == CMP_W'(r_exp)) begin
                                    res.bus_command = CMD_NACK;
                                end else begin
                                    res.bus_command = CMD_ACK;
                                end
                            end else if (st == ST_MR_DATA_NACK) begin
                                res.bus_command = CMD_STOP;
                                n_phase         = PH_IDLE;
                            end else begin
                                n_err   = ST_MR_DATA_ACK;
                                n_phase = PH_IDLE;
                            end
                        end else begin
                            if (st == ST_MT_DATA_ACK) begin
                                if (r_send >= r_fill) begin
                                    if (r_type == TY_ATOMIC) begin
                                        // write part done: repeated start into the read
                                        n_type          = TY_READ;
                                        res.bus_command = CMD_START;
                                        n_phase         = PH_START;
                                    end else begin
                                        res.bus_command = CMD_STOP;
                                        n_phase         = PH_IDLE;
                                    end
                                end else begin
                                    res.tx_valid = 1'b1;
                                    if (r_send < DEPTH_I) begin
                                        res.tx_byte = tx_rd;
                                        n_send      = r_send + 1'b1;
                                    end
                                    res.bus_command = CMD_NACK;
                                end
                            end else if (st == ST_MT_DATA_NACK) begin
                                res.bus_command = CMD_STOP;
                                n_phase         = PH_IDLE;
                            end else begin
                                n_err   = ST_MT_DATA_ACK;
                                n_phase = PH_IDLE;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            K_POP: begin
                if (r_drain < DEPTH_I) begin
                    res.read_data = rx_rd;
                    n_drain       = r_drain + 1'b1;
                    res.accepted  = 1'b1;
                end else begin
                    res.read_data = POP_EMPTY;
                end
            end
            K_KILL: begin
                res.bus_command = CMD_STOP;
                n_phase         = PH_IDLE;
            end
            default: begin
            end
        endcase

        // status as it stands after this item
        if (n_phase != PH_IDLE) begin
            res.error_status      = STAT_BUSY;
            res.completion_status = STAT_BUSY;
        end else begin
            res.error_status = n_err;
            if (n_send != n_fill) begin
                res.completion_status = STAT_WCUT + 8'(n_send);
            end else if (n_rcv != n_exp) begin
                res.completion_status = STAT_RCUT + 8'(n_rcv);
            end else begin
                res.completion_status = '0;
            end
        end
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_type   <= TY_WRITE;
            r_fill   <= '0;
            r_send   <= '0;
            r_rcv    <= '0;
            r_drain  <= '0;
            r_exp    <= '0;
            r_err    <= '0;
            r_target <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_type   <= n_type;
            r_fill   <= n_fill;
            r_send   <= n_send;
            r_rcv    <= n_rcv;
            r_drain  <= n_drain;
            r_exp    <= n_exp;
            r_err    <= n_err;
            r_target <= n_target;
        end
    end

    // byte stores: no reset, entries are defined once written
    always_ff @(posedge i_clk) begin
        if (i_step && tx_we) begin
            r_tx_mem[r_fill[ADDR_W-1:0]] <= i_item.write_data;
        end
        if (i_step && rx_we) begin
            r_rx_mem[r_rcv[ADDR_W-1:0]] <= i_item.rx_byte;
        end
    end

endmodule

>>> rtl/i2c_master_transaction_sequencer.sv
`timescale 1ns / 1ps

// I2C master transaction sequencer.
// Input channel (i_in_valid / o_in_stall / i_in_data) carries one item per
// transfer: setup, push byte, launch, bus status event, pop byte or kill.
// Output channel (o_out_valid / i_out_stall / o_out_data) returns exactly one
// result item per input item, in order: accept flag, bus command, byte to
// send, popped byte, busy/error status and completion status.
// An accepted item waits in the input register; the step logic processes it
// into the result register once that register can take a new result.
// Throughput: one item per cycle while the receiver does not stall. The step
// logic and all state update together as the result register loads.
// Stall: when the receiver stalls, the result register holds; the input
// register still takes one more item and then o_in_stall rises until the
// result moves on. Nothing is dropped or repeated.
// Reset (synchronous, active low): phase idle, all indices, expected read
// count, error code and target address cleared; both registers empty. Byte
// stores are not cleared and hold garbage until written.
module i2c_master_transaction_sequencer
    import i2cms_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    logic r_in_valid;
    t_in  r_in_data;
    logic r_out_valid;
    t_out r_out_data;

    logic out_free;
    logic step;
    t_out step_res;

    // result register can take a new result this cycle
    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    i2cms_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in_data),
        .o_result (step_res)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_data <= i_in_data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_data <= step_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> tb/sv/i2c_master_transaction_sequencer_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the I2C master transaction sequencer.
// A directed table opens the run, then random transactions follow; every
// accepted item is run through a local model of the sequencer and the
// result items coming back are checked against it in order.
module i2c_master_transaction_sequencer_tb;
    import i2cms_pkg::*;

    localparam int          RANDOM_ITEMS = 750;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          HOLD_CYCLES  = 40;
    localparam int          DRAIN_CYCLES = 8;
    localparam logic [2:0]  K_UNDEF      = 3'd7;   // no such kind, block must ignore it

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out_data;

    i2c_master_transaction_sequencer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Sequencer model state (mirrors what the block should hold)
    // ------------------------------------------------------------------
    logic [1:0]           ph;
    logic [1:0]           xfer;
    logic [7:0]           tx_mem [BUF_DEPTH];
    logic [7:0]           rx_mem [BUF_DEPTH];
    logic [BUF_DEPTH-1:0] tx_seen;     // store entries written at least once
    logic [BUF_DEPTH-1:0] rx_seen;
    logic [IDX_W-1:0]     fill_n;
    logic [IDX_W-1:0]     sent_n;
    logic [IDX_W-1:0]     recv_n;
    logic [IDX_W-1:0]     drain_n;
    logic [IDX_W-1:0]     want_n;
    logic [7:0]           err_code;
    logic [7:0]           slave_addr;

    t_out awaited_results [$];
    t_in  plan [$];
    int   mismatches = 0;
    int   n_results  = 0;
    int   cycle_count = 0;
    int   sender_idle_pct = 10;
    int   recv_stall_pct  = 45;
    int   hold_asks = 0;      // bumped by the driver, served by the receiver

    typedef struct {
        t_in  item;
        bit   typed;
        t_out want;
    } t_directed_row;

    t_directed_row directed_rows [$];

    function automatic t_in mk(logic [2:0] k, logic [4:0] rc, logic [7:0] wd,
                               logic [7:0] da, logic [7:0] st, logic [7:0] rx);
        t_in it;
        it.kind = k;
        it.read_count = rc;
        it.write_data = wd;
        it.device_address = da;
        it.bus_status = st;
        it.rx_byte = rx;
        return it;
    endfunction

    function automatic t_out outcome(logic acc, logic [2:0] cmd, logic txv,
                                     logic [7:0] txb, logic [7:0] rd,
                                     logic [7:0] es, logic [7:0] cs);
        return {acc, cmd, txv, txb, rd, es, cs};
    endfunction

    function automatic void add_row(t_in it, bit typed = 1'b0, t_out want = '0);
        t_directed_row r;
        r.item = it;
        r.typed = typed;
        r.want = want;
        directed_rows.push_back(r);
    endfunction

    // Next transmit byte; the send pointer saturates at the buffer depth.
    task automatic load_next(output logic [7:0] b);
        if (sent_n < BUF_DEPTH) begin
            b = tx_mem[sent_n[ADDR_W-1:0]];
            sent_n++;
        end else begin
            b = 8'h00;
        end
    endtask

    // One item through the sequencer: updates the model and gives its result.
    task automatic sequence_step(input t_in it, output t_out r);
        logic [7:0] st;
        st = it.bus_status & ST_MASK;
        r = '0;
        case (it.kind)
            K_SETUP: begin
                want_n  = (it.read_count > BUF_DEPTH) ? IDX_W'(BUF_DEPTH) : it.read_count;
                fill_n  = '0;
                sent_n  = '0;
                recv_n  = '0;
                drain_n = '0;
            end
            K_PUSH: begin
                if (fill_n < BUF_DEPTH) begin
                    tx_mem[fill_n[ADDR_W-1:0]] = it.write_data;
                    tx_seen[fill_n[ADDR_W-1:0]] = 1'b1;
                    fill_n++;
                    r.accepted = 1'b1;
                end
            end
            K_LAUNCH: begin
                // rejected outright while a transfer is running
                if (ph == PH_IDLE) begin
                    err_code = 8'h00;
                    slave_addr = it.device_address & ADDR_MASK;
                    if (fill_n != 0 || want_n != 0) begin
                        if (fill_n == 0)
                            xfer = TY_READ;
                        else
                            xfer = (want_n != 0) ? TY_ATOMIC : TY_WRITE;
                        r.bus_command = CMD_START;
                        r.accepted = 1'b1;
                        ph = PH_START;
                    end
                end
            end
            K_EVENT: begin
                case (ph)
                    PH_START: begin
                        if (st == ST_START || st == ST_RSTART) begin
                            r.tx_valid = 1'b1;
                            r.tx_byte = slave_addr | 8'(xfer == TY_READ);
                            r.bus_command = CMD_NACK;
                            ph = PH_ADDRESS;
                        end else begin
                            err_code = st;
                            ph = PH_IDLE;
                        end
                    end
                    PH_ADDRESS: begin
                        if (xfer == TY_READ) begin
                            if (st == ST_MR_SLA_ACK) begin
                                r.bus_command = (want_n == 1) ? CMD_NACK : CMD_ACK;
                                ph = PH_DATA;
                            end else if (st == ST_MR_SLA_NACK) begin
                                r.bus_command = CMD_STOP;
                                ph = PH_IDLE;
                            end else begin
                                err_code = st;
                                ph = PH_IDLE;
                            end
                        end else begin
                            if (st == ST_MT_SLA_ACK) begin
                                r.tx_valid = 1'b1;
                                load_next(r.tx_byte);
                                r.bus_command = CMD_NACK;
                                ph = PH_DATA;
                            end else if (st == ST_MT_SLA_NACK) begin
                                r.bus_command = CMD_STOP;
                                ph = PH_IDLE;
                            end else begin
                                err_code = st;
                                ph = PH_IDLE;
                            end
                        end
                    end
                    PH_DATA: begin
                        if (xfer == TY_READ) begin
                            // byte is kept whatever the status, dropped once full
                            if (recv_n < BUF_DEPTH) begin
                                rx_mem[recv_n[ADDR_W-1:0]] = it.rx_byte;
                                rx_seen[recv_n[ADDR_W-1:0]] = 1'b1;
                                recv_n++;
                            end
                            if (st == ST_MR_DATA_ACK) begin
                                if (recv_n == want_n || recv_n >= BUF_DEPTH) begin
                                    r.bus_command = CMD_STOP;
                                    ph = PH_IDLE;
                                end else if (recv_n + 1 == want_n) begin
                                    r.bus_command = CMD_NACK;
                                end else begin
                                    r.bus_command = CMD_ACK;
                                end
                            end else if (st == ST_MR_DATA_NACK) begin
                                r.bus_command = CMD_STOP;
                                ph = PH_IDLE;
                            end else begin
                                err_code = ST_MR_DATA_ACK;
                                ph = PH_IDLE;
                            end
                        end else begin
                            if (st == ST_MT_DATA_ACK) begin
                                if (sent_n >= fill_n) begin
                                    // write part done: atomic turns around into a read
                                    if (xfer == TY_ATOMIC) begin
                                        xfer = TY_READ;
                                        r.bus_command = CMD_START;
                                        ph = PH_START;
                                    end else begin
                                        r.bus_command = CMD_STOP;
                                        ph = PH_IDLE;
                                    end
                                end else begin
                                    r.tx_valid = 1'b1;
                                    load_next(r.tx_byte);
                                    r.bus_command = CMD_NACK;
                                end
                            end else if (st == ST_MT_DATA_NACK) begin
                                r.bus_command = CMD_STOP;
                                ph = PH_IDLE;
                            end else begin
                                err_code = ST_MT_DATA_ACK;
                                ph = PH_IDLE;
                            end
                        end
                    end
                    default: ;  // idle: event ignored
                endcase
            end
            K_POP: begin
                if (drain_n < BUF_DEPTH) begin
                    r.read_data = rx_mem[drain_n[ADDR_W-1:0]];
                    drain_n++;
                    r.accepted = 1'b1;
                end else begin
                    r.read_data = POP_EMPTY;
                end
            end
            K_KILL: begin
                r.bus_command = CMD_STOP;
                ph = PH_IDLE;
            end
            default: ;
        endcase

        if (ph != PH_IDLE) begin
            r.error_status = STAT_BUSY;
            r.completion_status = STAT_BUSY;
        end else begin
            r.error_status = err_code;
            if (sent_n != fill_n)
                r.completion_status = STAT_WCUT + sent_n;
            else if (recv_n != want_n)
                r.completion_status = STAT_RCUT + recv_n;
            else
                r.completion_status = 8'h00;
        end
    endtask

    // True if the item would pop or send a store entry never written.
    function automatic bit reads_unwritten_entry(t_in it);
        if (it.kind == K_POP)
            return drain_n < BUF_DEPTH && !rx_seen[drain_n[ADDR_W-1:0]];
        if (it.kind == K_EVENT && ph == PH_ADDRESS && xfer != TY_READ &&
            (it.bus_status & ST_MASK) == ST_MT_SLA_ACK)
            return sent_n < BUF_DEPTH && !tx_seen[sent_n[ADDR_W-1:0]];
        return 1'b0;
    endfunction

    function automatic t_in scrambled(logic [2:0] k);
        logic [63:0] raw;
        t_in it;
        raw = {$urandom, $urandom};
        it = raw[$bits(t_in)-1:0];
        it.kind = k;
        return it;
    endfunction

    // Bus status that mostly moves the transfer on, sometimes NACKs or fails.
    function automatic logic [7:0] pick_status();
        logic [7:0] ack, nack;
        logic [2:0] low;
        int u, pa, pn;
        bit rd;
        low = 3'($urandom_range(0, 7));
        u = $urandom_range(99);
        rd = (xfer == TY_READ);
        if (ph == PH_START) begin
            ack = ST_START;
            nack = ST_RSTART;    // repeated start is just as good here
            pa = 44;
            pn = 88;
        end else if (ph == PH_ADDRESS) begin
            ack = rd ? ST_MR_SLA_ACK : ST_MT_SLA_ACK;
            nack = rd ? ST_MR_SLA_NACK : ST_MT_SLA_NACK;
            pa = 85;
            pn = 93;
        end else begin
            ack = rd ? ST_MR_DATA_ACK : ST_MT_DATA_ACK;
            nack = rd ? ST_MR_DATA_NACK : ST_MT_DATA_NACK;
            pa = 94;
            pn = 97;
        end
        if (u < pa)
            return ack | low;
        if (u < pn)
            return nack | low;
        return 8'($urandom);
    endfunction

    // Random item: mostly whole transactions (setup, pushes, launch, then
    // bus events steered by the model's phase), pops to drain, some noise.
    task automatic choose_item(output t_in it);
        int u, rc, n;
        u = $urandom_range(99);
        if (ph != PH_IDLE) begin
            if (u < 92) begin
                it = scrambled(K_EVENT);
                it.bus_status = pick_status();
            end else if (u < 95) begin
                it = scrambled(K_KILL);
            end else begin
                it = scrambled(3'($urandom_range(0, 7)));
            end
        end else begin
            if (plan.size() == 0) begin
                if (u < 55) begin
                    u = $urandom_range(99);
                    if (u < 30)
                        rc = 0;
                    else if (u < 65)
                        rc = $urandom_range(1, 4);
                    else if (u < 90)
                        rc = BUF_DEPTH;
                    else
                        rc = $urandom_range(BUF_DEPTH + 1, 31);
                    u = $urandom_range(99);
                    if (u < 10)
                        n = 0;
                    else if (u < 85)
                        n = $urandom_range(1, 4);
                    else
                        n = $urandom_range(BUF_DEPTH - 1, BUF_DEPTH + 2);
                    it = scrambled(K_SETUP);
                    it.read_count = 5'(rc);
                    plan.push_back(it);
                    repeat (n) plan.push_back(scrambled(K_PUSH));
                    plan.push_back(scrambled(K_LAUNCH));
                end else if (u < 75) begin
                    n = (recv_n > drain_n) ? int'(recv_n - drain_n) : 0;
                    n += $urandom_range(0, 2);
                    if (n == 0)
                        n = 1;
                    repeat (n) plan.push_back(scrambled(K_POP));
                end else begin
                    plan.push_back(scrambled(3'($urandom_range(0, 7))));
                end
            end
            it = plan.pop_front();
        end
        if (reads_unwritten_entry(it))
            it.kind = K_KILL;
    endtask

    task automatic offer_item(input t_in item);
        if ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        t_in  item;
        t_out res;
        int   counted;
        bit   hold_given;

        counted = 0;
        hold_given = 1'b0;
        ph = PH_IDLE;
        xfer = TY_WRITE;
        tx_seen = '0;
        rx_seen = '0;
        fill_n = '0;
        sent_n = '0;
        recv_n = '0;
        drain_n = '0;
        want_n = '0;
        err_code = 8'h00;
        slave_addr = 8'h00;

        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // undefined kind, empty launch and stray event straight after reset
        add_row(mk(K_UNDEF, 5'd31, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b1,
                outcome(1'b0, CMD_NONE, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
        add_row(mk(K_LAUNCH, 5'd0, 8'h00, 8'hFF, 8'h00, 8'h00), 1'b1,
                outcome(1'b0, CMD_NONE, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
        add_row(mk(K_EVENT, 5'd0, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1,
                outcome(1'b0, CMD_NONE, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
        // read count beyond the buffer saturates to a full read
        add_row(mk(K_SETUP, 5'd31, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1,
                outcome(1'b0, CMD_NONE, 1'b0, 8'h00, 8'h00, 8'h00, STAT_RCUT));
        add_row(mk(K_LAUNCH, 5'd0, 8'h00, 8'hA5, 8'h00, 8'h00), 1'b1,
                outcome(1'b1, CMD_START, 1'b0, 8'h00, 8'h00, STAT_BUSY, STAT_BUSY));
        // start status with low bits set: address goes out with the read bit
        add_row(mk(K_EVENT, 5'd0, 8'h00, 8'h00, 8'h0F, 8'h00), 1'b1,
                outcome(1'b0, CMD_NACK, 1'b1, 8'hA5, 8'h00, STAT_BUSY, STAT_BUSY));
        add_row(mk(K_EVENT, 5'd0, 8'h00, 8'h00, 8'h47, 8'h00));
        add_row(mk(K_EVENT, 5'd0, 8'h00, 8'h00, ST_MR_DATA_ACK, 8'h00));
        add_row(mk(K_EVENT, 5'd0, 8'h00, 8'h00, 8'h57, 8'hFF));
        add_row(mk(K_EVENT, 5'd0, 8'h00, 8'h00, ST_MR_DATA_NACK, 8'h5A));
        repeat (3) add_row(mk(K_POP, 5'd0, 8'h00, 8'h00, 8'h00, 8'h00));
        // two-byte write, then a relaunch refused at the address
        add_row(mk(K_SETUP, 5'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b1,
                outcome(1'b0, CMD_NONE, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
        add_row(mk(K_PUSH, 5'd0, 8'h00, 8'h00, 8'h00, 8'h00));
        add_row(mk(K_PUSH, 5'd0, 8'hFF, 8'h00, 8'h00, 8'h00));
        add_row(mk(K_LAUNCH, 5'd0, 8'h00, 8'h00, 8'h00, 8'h00));
        add_row(mk(K_EVENT, 5'd0, 8'h00, 8'h00, ST_START, 8'h00));
        add_row(mk(K_EVENT, 5'd0, 8'h00, 8'h00, ST_MT_SLA_ACK, 8'h00));
        add_row(mk(K_EVENT, 5'd0, 8'h00, 8'h00, ST_MT_DATA_ACK, 8'h00));
        add_row(mk(K_EVENT, 5'd0, 8'h00, 8'h00, ST_MT_DATA_ACK, 8'h00));
        add_row(mk(K_LAUNCH, 5'd0, 8'h00, 8'h10, 8'h00, 8'h00));
        add_row(mk(K_EVENT, 5'd0, 8'h00, 8'h00, ST_RSTART, 8'h00));
        add_row(mk(K_EVENT, 5'd0, 8'h00, 8'h00, ST_MT_SLA_NACK, 8'h00));
        // launch while busy is refused; a bad start status is recorded
        add_row(mk(K_LAUNCH, 5'd0, 8'h00, 8'h7E, 8'h00, 8'h00));
        add_row(mk(K_LAUNCH, 5'd0, 8'h00, 8'h80, 8'h00, 8'h00), 1'b1,
                outcome(1'b0, CMD_NONE, 1'b0, 8'h00, 8'h00, STAT_BUSY, STAT_BUSY));
        add_row(mk(K_EVENT, 5'd0, 8'h00, 8'h00, 8'hF8, 8'h00), 1'b1,
                outcome(1'b0, CMD_NONE, 1'b0, 8'h00, 8'h00, 8'hF8, 8'h00));
        add_row(mk(K_KILL, 5'd0, 8'h00, 8'h00, 8'h00, 8'h00));

        foreach (directed_rows[i]) begin
            offer_item(directed_rows[i].item);
            sequence_step(directed_rows[i].item, res);
            awaited_results.push_back(directed_rows[i].typed ? directed_rows[i].want : res);
        end

        // random part in three idling regimes; long receiver hold in the last
        while (counted < RANDOM_ITEMS) begin
            if (counted < RANDOM_ITEMS / 3) begin
                sender_idle_pct = 10;
                recv_stall_pct = 45;
            end else if (counted < 2 * RANDOM_ITEMS / 3) begin
                sender_idle_pct = 45;
                recv_stall_pct = 10;
            end else begin
                sender_idle_pct = 0;
                recv_stall_pct = 0;
                if (!hold_given && counted >= 2 * RANDOM_ITEMS / 3 + 20) begin
                    hold_asks <= hold_asks + 1;
                    hold_given = 1'b1;
                end
            end
            choose_item(item);
            if (!(item.kind > K_KILL || (item.kind == K_EVENT && ph == PH_IDLE)))
                counted++;
            offer_item(item);
            sequence_step(item, res);
            awaited_results.push_back(res);
        end
        i_in_valid <= 1'b0;

        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off counted here.
    initial begin
        int hold_left;
        int hold_served;
        hold_left = 0;
        hold_served = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0 && hold_asks != hold_served) begin
                hold_left = HOLD_CYCLES;
                hold_served++;
            end
            if (hold_left != 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Result checker: oldest expectation first, every field compared.
    always @(posedge i_clk) begin : check_results
        t_out want;
        t_out got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = o_out_data;
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d exp: none, got: %h", n_results, got);
            end else begin
                want = awaited_results.pop_front();
                if (got.accepted !== want.accepted ||
                    got.bus_command !== want.bus_command ||
                    got.tx_valid !== want.tx_valid ||
                    got.tx_byte !== want.tx_byte ||
                    got.read_data !== want.read_data ||
                    got.error_status !== want.error_status ||
                    got.completion_status !== want.completion_status) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d exp acc=%0d cmd=%0d txv=%0d txb=%h rd=%h es=%h cs=%h",
                                 n_results, want.accepted, want.bus_command, want.tx_valid,
                                 want.tx_byte, want.read_data, want.error_status,
                                 want.completion_status);
                        $display("result %0d got acc=%0d cmd=%0d txv=%0d txb=%h rd=%h es=%h cs=%h",
                                 n_results, got.accepted, got.bus_command, got.tx_valid,
                                 got.tx_byte, got.read_data, got.error_status,
                                 got.completion_status);
                    end
                end
            end
            n_results++;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule
